// ===== sv/esc_pkg.sv =====
// ---------------------------------------------------------------------------
// esc_pkg
// shared widths, constants, the month table, a month start function and types for the epoch converter
// ---------------------------------------------------------------------------
package esc_pkg;

    localparam int SECS_W   = 38;
    localparam int SUB_W    = SECS_W;
    localparam int YSEC_W   = 25;
    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int MDAY_W   = 5;
    localparam int HOUR_W   = 5;
    localparam int MIN_W    = 6;
    localparam int SEC_W    = 6;

    localparam int LAST_YEAR     = 9999;
    localparam int FIRST_YEAR    = 1970;
    localparam int SECS_PER_DAY  = 86400;
    localparam int SECS_PER_HOUR = 3600;
    localparam int SECS_PER_MIN  = 60;
    localparam int DAYS_COMMON   = 365;
    localparam int DAYS_LEAP     = 366;
    localparam int MONTHS        = 12;

    localparam int SECS_COMMON_YEAR = DAYS_COMMON * SECS_PER_DAY;
    localparam int SECS_LEAP_YEAR   = DAYS_LEAP * SECS_PER_DAY;

    localparam logic [1:0] FIRST_MOD4   = 2'(FIRST_YEAR % 4);
    localparam logic [6:0] FIRST_MOD100 = 7'(FIRST_YEAR % 100);
    localparam logic [8:0] FIRST_MOD400 = 9'(FIRST_YEAR % 400);

    // first second of each month in a common year
    localparam logic [YSEC_W-1:0] MONTH_START [13] = '{
        25'd0, 25'd2678400, 25'd5097600, 25'd7776000, 25'd10368000,
        25'd13046400, 25'd15638400, 25'd18316800, 25'd20995200,
        25'd23587200, 25'd26265600, 25'd28857600, 25'd31536000
    };

    // first second of month idx within the year, idx 0..12
    function automatic logic [SUB_W-1:0] month_start(input logic leap,
                                                     input logic [MONTH_W-1:0] idx);
        logic [SUB_W-1:0] base;
        base = '0;
        if (idx <= MONTH_W'(MONTHS))
        begin
            base = SUB_W'(MONTH_START[idx]);
        end
        if (leap && idx >= MONTH_W'(2) && idx <= MONTH_W'(MONTHS))
        begin
            base = base + SUB_W'(SECS_PER_DAY);
        end
        return base;
    endfunction

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_YEAR  = 8'b0000_0010,
        ST_MONTH = 8'b0000_0100,
        ST_MBASE = 8'b0000_1000,
        ST_MDAY  = 8'b0001_0000,
        ST_HOUR  = 8'b0010_0000,
        ST_MIN   = 8'b0100_0000,
        ST_DONE  = 8'b1000_0000
    } esc_state_t;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [MDAY_W-1:0]  day_of_month;
        logic [HOUR_W-1:0]  hour;
        logic [MIN_W-1:0]   minute;
        logic [SEC_W-1:0]   second;
        logic               out_of_range;
    } esc_res_t;

endpackage

// ===== sv/esc_if.sv =====
// ---------------------------------------------------------------------------
// esc_if
// valid/ready channels for the epoch seconds beat and the calendar beat
// ---------------------------------------------------------------------------
interface esc_in_if import esc_pkg::*;;
    logic              valid;
    logic              ready;
    logic [SECS_W-1:0] zoned_seconds;

    modport source (output valid, output zoned_seconds, input ready);
    modport sink   (input valid, input zoned_seconds, output ready);
endinterface

interface esc_out_if import esc_pkg::*;;
    logic               valid;
    logic               ready;
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [MDAY_W-1:0]  day_of_month;
    logic [HOUR_W-1:0]  hour;
    logic [MIN_W-1:0]   minute;
    logic [SEC_W-1:0]   second;
    logic               out_of_range;

    modport source (output valid, output year, output month, output day_of_month,
                    output hour, output minute, output second, output out_of_range,
                    input ready);
    modport sink   (input valid, input year, input month, input day_of_month,
                    input hour, input minute, input second, input out_of_range,
                    output ready);
endinterface

// ===== sv/esc_sub.sv =====
// ---------------------------------------------------------------------------
// esc_sub
// shared subtract and compare unit: a - b and a >= b
// ---------------------------------------------------------------------------
module esc_sub import esc_pkg::*;
(
    input  logic [SUB_W-1:0] a,
    input  logic [SUB_W-1:0] b,
    output logic [SUB_W-1:0] diff,
    output logic             ge
);

    logic [SUB_W:0] full;

    assign full = {1'b0, a} - {1'b0, b};
    assign diff = full[SUB_W-1:0];
    assign ge   = ~full[SUB_W];

endmodule

// ===== sv/esc_seq.sv =====
// ---------------------------------------------------------------------------
// esc_seq
// sequencer: year walk, month search, day, hour and minute count,
// all through one shared subtract/compare unit on the second count
// ---------------------------------------------------------------------------
module esc_seq import esc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [SECS_W-1:0] secs,
    output logic              idle,
    output logic              res_valid,
    input  logic              res_ready,
    output esc_res_t          res
);

    esc_state_t         state_reg, state_next;
    logic [SECS_W-1:0]  secs_reg, secs_next;
    logic [YEAR_W-1:0]  year_reg, year_next;
    logic [1:0]         mod4_reg, mod4_next;
    logic [6:0]         mod100_reg, mod100_next;
    logic [8:0]         mod400_reg, mod400_next;
    logic [MONTH_W-1:0] mon_reg, mon_next;
    logic [MDAY_W-1:0]  mday_reg, mday_next;
    logic [HOUR_W-1:0]  hour_reg, hour_next;
    logic [MIN_W-1:0]   min_reg, min_next;
    logic               oor_reg, oor_next;

    logic [SUB_W-1:0]   sub_a, sub_b, sub_diff;
    logic               sub_ge;
    logic               leap;

    assign leap = (mod4_reg == 2'd0) && ((mod100_reg != 7'd0) || (mod400_reg == 9'd0));

    always_comb
    begin
        sub_a = '0;
        sub_b = '0;
        case (state_reg)
            ST_YEAR:
            begin
                sub_a = secs_reg;
                sub_b = leap ? SUB_W'(SECS_LEAP_YEAR) : SUB_W'(SECS_COMMON_YEAR);
            end
            ST_MONTH:
            begin
                sub_a = secs_reg;
                sub_b = month_start(leap, mon_reg);
            end
            ST_MBASE:
            begin
                sub_a = secs_reg;
                sub_b = month_start(leap, mon_reg - MONTH_W'(1));
            end
            ST_MDAY:
            begin
                sub_a = secs_reg;
                sub_b = SUB_W'(SECS_PER_DAY);
            end
            ST_HOUR:
            begin
                sub_a = secs_reg;
                sub_b = SUB_W'(SECS_PER_HOUR);
            end
            ST_MIN:
            begin
                sub_a = secs_reg;
                sub_b = SUB_W'(SECS_PER_MIN);
            end
            default:
            begin
                sub_a = '0;
                sub_b = '0;
            end
        endcase
    end

    esc_sub u_sub (
        .a    (sub_a),
        .b    (sub_b),
        .diff (sub_diff),
        .ge   (sub_ge)
    );

    always_comb
    begin
        state_next  = state_reg;
        secs_next   = secs_reg;
        year_next   = year_reg;
        mod4_next   = mod4_reg;
        mod100_next = mod100_reg;
        mod400_next = mod400_reg;
        mon_next    = mon_reg;
        mday_next   = mday_reg;
        hour_next   = hour_reg;
        min_next    = min_reg;
        oor_next    = oor_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    secs_next   = secs;
                    year_next   = YEAR_W'(FIRST_YEAR);
                    mod4_next   = FIRST_MOD4;
                    mod100_next = FIRST_MOD100;
                    mod400_next = FIRST_MOD400;
                    mon_next    = MONTH_W'(1);
                    mday_next   = MDAY_W'(1);
                    hour_next   = '0;
                    min_next    = '0;
                    oor_next    = 1'b0;
                    state_next  = ST_YEAR;
                end
            end
            ST_YEAR:
            begin
                if (year_reg > YEAR_W'(LAST_YEAR))
                begin
                    oor_next   = 1'b1;
                    state_next = ST_DONE;
                end
                else if (!sub_ge)
                begin
                    state_next = ST_MONTH;
                end
                else
                begin
                    secs_next   = sub_diff;
                    year_next   = year_reg + YEAR_W'(1);
                    mod4_next   = mod4_reg + 2'd1;
                    mod100_next = (mod100_reg == 7'd99) ? 7'd0 : mod100_reg + 7'd1;
                    mod400_next = (mod400_reg == 9'd399) ? 9'd0 : mod400_reg + 9'd1;
                end
            end
            ST_MONTH:
            begin
                if (mon_reg < MONTH_W'(MONTHS) && sub_ge)
                begin
                    mon_next = mon_reg + MONTH_W'(1);
                end
                else
                begin
                    state_next = ST_MBASE;
                end
            end
            ST_MBASE:
            begin
                secs_next  = sub_diff;
                mday_next  = MDAY_W'(1);
                state_next = ST_MDAY;
            end
            ST_MDAY:
            begin
                if (sub_ge)
                begin
                    secs_next = sub_diff;
                    mday_next = mday_reg + MDAY_W'(1);
                end
                else
                begin
                    state_next = ST_HOUR;
                end
            end
            ST_HOUR:
            begin
                if (sub_ge)
                begin
                    secs_next = sub_diff;
                    hour_next = hour_reg + HOUR_W'(1);
                end
                else
                begin
                    state_next = ST_MIN;
                end
            end
            ST_MIN:
            begin
                if (sub_ge)
                begin
                    secs_next = sub_diff;
                    min_next  = min_reg + MIN_W'(1);
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        secs_reg   <= secs_next;
        year_reg   <= year_next;
        mod4_reg   <= mod4_next;
        mod100_reg <= mod100_next;
        mod400_reg <= mod400_next;
        mon_reg    <= mon_next;
        mday_reg   <= mday_next;
        hour_reg   <= hour_next;
        min_reg    <= min_next;
        oor_reg    <= oor_next;
    end

    assign idle      = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);

    always_comb
    begin
        res.out_of_range = oor_reg;
        if (oor_reg)
        begin
            res.year         = '0;
            res.month        = '0;
            res.day_of_month = '0;
            res.hour         = '0;
            res.minute       = '0;
            res.second       = '0;
        end
        else
        begin
            res.year         = year_reg;
            res.month        = mon_reg;
            res.day_of_month = mday_reg;
            res.hour         = hour_reg;
            res.minute       = min_reg;
            res.second       = secs_reg[SEC_W-1:0];
        end
    end

endmodule

// ===== sv/epoch_seconds_to_calendar.sv =====
// ---------------------------------------------------------------------------
// epoch_seconds_to_calendar
// epoch seconds to gregorian year, month, day and time of day
// ---------------------------------------------------------------------------
//  port    dir   beat
//  stamp   sink  zoned_seconds
//  cal     src   year, month, day_of_month, hour, minute, second, out_of_range
//
//  one beat is accepted, then the years are walked from 1970 one by one by
//  subtracting the year length in seconds, the month is searched by compares
//  against the month starts, the month base is subtracted, and days, hours and
//  minutes are counted by subtraction before the done state holds the result,
//  all of it through one shared subtract/compare unit; stamp.ready is low
//  while a beat is in work; the result sits in an output register so a new
//  beat is taken while cal is stalled; asynchronous active-low reset
// ---------------------------------------------------------------------------
module epoch_seconds_to_calendar import esc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    esc_in_if.sink     stamp,
    esc_out_if.source  cal
);

    logic     seq_idle;
    logic     res_valid;
    logic     res_ready;
    esc_res_t res;
    esc_res_t out_reg;
    logic     out_valid_reg;

    assign stamp.ready = seq_idle;
    assign res_ready   = !out_valid_reg || cal.ready;

    esc_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (stamp.valid),
        .secs      (stamp.zoned_seconds),
        .idle      (seq_idle),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res;
        end
    end

    assign cal.valid        = out_valid_reg;
    assign cal.year         = out_reg.year;
    assign cal.month        = out_reg.month;
    assign cal.day_of_month = out_reg.day_of_month;
    assign cal.hour         = out_reg.hour;
    assign cal.minute       = out_reg.minute;
    assign cal.second       = out_reg.second;
    assign cal.out_of_range = out_reg.out_of_range;

endmodule
